// ----- rtl/core/stq_pkg.sv -----
// Shared constants, codes and transfer types for the sorted timer queue.
`default_nettype none

package stq_pkg;

	localparam int NUM_TIMERS = 16;
	localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int TID_W      = 4;
	localparam int TIME_W     = 64;

	localparam logic [2:0] OP_ARM     = 3'd0;
	localparam logic [2:0] OP_CANCEL  = 3'd1;
	localparam logic [2:0] OP_PENDING = 3'd2;
	localparam logic [2:0] OP_EXPIRED = 3'd3;
	localparam logic [2:0] OP_RUN     = 3'd4;

	localparam logic [1:0] KIND_PENDING = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_FIRED   = 2'd2;

	typedef struct packed {
		logic [2:0]               opcode;
		logic [TID_W-1:0]         timer_id;
		logic signed [TIME_W-1:0] expire_at;
		logic signed [TIME_W-1:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [TID_W-1:0] fired_id;
		logic             answer_flag;
		logic             last_result;
	} result_t;

	// status from the shared compare unit
	typedef struct packed {
		logic later;   // cell expire strictly later than reference time
		logic id_hit;  // cell timer equals the timer being looked for
	} cmp_t;

endpackage

`default_nettype wire

// ----- rtl/core/stq_cmp.sv -----
// Shared compare unit: signed 64-bit time compare and timer number match.
`default_nettype none

module stq_cmp import stq_pkg::*; (
	input  logic signed [TIME_W-1:0] cell_expire,
	input  logic signed [TIME_W-1:0] ref_time,
	input  logic [TID_W-1:0]         cell_id,
	input  logic [TID_W-1:0]         want_id,
	output cmp_t                     flags
);

	always_comb begin
		flags.later  = (cell_expire > ref_time);
		flags.id_hit = (cell_id == want_id);
	end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_timer_queue_unit.sv -----
// Top level of the sorted timer queue: cell list, sequencer and result register.
`default_nettype none

// Channel  | Ports                  | Transfer when
// ---------+------------------------+----------------------------------------
// command  | start, busy, cmd       | rising edge with start high, busy low
// result   | result_valid, result   | every edge ending a result_valid cycle
//
// Steps: arm first scans for its old entry and then for the insert slot;
// cancel and pending scan for the entry, expired reads the head only, and run
// removes due entries from the head one at a time. All scans go through the
// single compare unit, one cell a cycle.
// Reset empties the list at once (valid bits only); no clearing pass.
// Results come from a register in the cycle after they are decided; the receiver
// cannot stall, and busy is low again by the time the final result shows.

module sorted_timer_queue_unit import stq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    result_valid,
	output result_t result
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FIND = 3'd1;
	localparam logic [2:0] ST_INS  = 3'd2;
	localparam logic [2:0] ST_EXP  = 3'd3;
	localparam logic [2:0] ST_RUN  = 3'd4;

	logic [2:0]               state_q;
	logic [2:0]               op_q;
	logic [TID_W-1:0]         id_q;
	logic signed [TIME_W-1:0] when_q;
	logic signed [TIME_W-1:0] now_q;
	logic [IDX_W-1:0]         ptr_q;
	logic [NUM_TIMERS-1:0]    valid_q;
	logic                     held_v_q;
	logic [TID_W-1:0]         held_id_q;
	logic                     result_valid_q;
	result_t                  result_q;

	// list cells, kept as a valid prefix in list order
	logic [TID_W-1:0]         cell_timer_q  [NUM_TIMERS];
	logic signed [TIME_W-1:0] cell_expire_q [NUM_TIMERS];

	logic signed [TIME_W-1:0] cmp_ref;
	cmp_t                     cmp;
	logic                     cur_valid;
	logic                     ptr_last;
	logic                     head_due;
	logic                     do_remove;
	logic                     do_insert;

	// insert scan compares against the new expire time, everything else against now
	assign cmp_ref = (state_q == ST_INS) ? when_q : now_q;

	stq_cmp u_cmp (
		.cell_expire (cell_expire_q[ptr_q]),
		.ref_time    (cmp_ref),
		.cell_id     (cell_timer_q[ptr_q]),
		.want_id     (id_q),
		.flags       (cmp)
	);

	assign cur_valid = valid_q[ptr_q];
	assign ptr_last  = (ptr_q == IDX_W'(NUM_TIMERS - 1));
	// ptr_q stays at the head during expired and run
	assign head_due  = valid_q[0] && !cmp.later;

	// remove: found entry on arm or cancel, or due head on run
	assign do_remove = ((state_q == ST_FIND) && cur_valid && cmp.id_hit &&
	                    ((op_q == OP_ARM) || (op_q == OP_CANCEL))) ||
	                   ((state_q == ST_RUN) && head_due);
	// insert in front of the first free or strictly later cell
	assign do_insert = (state_q == ST_INS) && !valid_q[NUM_TIMERS-1] &&
	                   (!cur_valid || cmp.later);

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// cell payload: whole-row shifts, one per cycle
	always_ff @(posedge clk) begin
		if (do_remove) begin
			for (int j = 0; j < NUM_TIMERS - 1; j++) begin
				if (IDX_W'(j) >= ptr_q) begin
					cell_timer_q[j]  <= cell_timer_q[j+1];
					cell_expire_q[j] <= cell_expire_q[j+1];
				end
			end
		end else if (do_insert) begin
			for (int j = 1; j < NUM_TIMERS; j++) begin
				if (IDX_W'(j) > ptr_q) begin
					cell_timer_q[j]  <= cell_timer_q[j-1];
					cell_expire_q[j] <= cell_expire_q[j-1];
				end
			end
			cell_timer_q[ptr_q]  <= id_q;
			cell_expire_q[ptr_q] <= when_q;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_FIND: begin
				result_q.result_kind <= KIND_PENDING;
				result_q.fired_id    <= id_q;
				result_q.answer_flag <= cur_valid && cmp.id_hit;
				result_q.last_result <= 1'b1;
			end
			ST_EXP: begin
				result_q.result_kind <= KIND_EXPIRED;
				result_q.fired_id    <= valid_q[0] ? cell_timer_q[0] : '0;
				result_q.answer_flag <= head_due;
				result_q.last_result <= 1'b1;
			end
			ST_RUN: begin
				result_q.result_kind <= KIND_FIRED;
				result_q.fired_id    <= held_id_q;
				result_q.answer_flag <= 1'b0;
				result_q.last_result <= !head_due;
			end
			default: begin
				result_q <= result_q;
			end
		endcase
		if ((state_q == ST_RUN) && head_due) begin
			held_id_q <= cell_timer_q[0];
		end
		if ((state_q == ST_IDLE) && start) begin
			op_q   <= cmd.opcode;
			id_q   <= cmd.timer_id;
			when_q <= cmd.expire_at;
			now_q  <= cmd.now_time;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ptr_q          <= '0;
			valid_q        <= '0;
			held_v_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			if (do_remove) begin
				valid_q <= valid_q >> 1;
			end else if (do_insert) begin
				valid_q <= (valid_q << 1) | NUM_TIMERS'(1);
			end
			case (state_q)
				ST_IDLE: begin
					ptr_q    <= '0;
					held_v_q <= 1'b0;
					if (start) begin
						case (cmd.opcode)
							OP_ARM: begin
								if (32'(cmd.timer_id) < NUM_TIMERS) begin
									state_q <= ST_FIND;
								end
							end
							OP_CANCEL:  state_q <= ST_FIND;
							OP_PENDING: state_q <= ST_FIND;
							OP_EXPIRED: state_q <= ST_EXP;
							OP_RUN:     state_q <= ST_RUN;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FIND: begin
					if (!cur_valid || cmp.id_hit || ptr_last) begin
						// scan over: found, end of list or last cell
						ptr_q          <= '0;
						result_valid_q <= (op_q == OP_PENDING);
						state_q        <= (op_q == OP_ARM) ? ST_INS : ST_IDLE;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				ST_INS: begin
					if (valid_q[NUM_TIMERS-1] || !cur_valid || cmp.later || ptr_last) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + IDX_W'(1);
					end
				end
				ST_EXP: begin
					result_valid_q <= 1'b1;
					state_q        <= ST_IDLE;
				end
				ST_RUN: begin
					// one entry held back so the final one can be marked
					result_valid_q <= held_v_q;
					held_v_q       <= head_due;
					if (!head_due) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/stq_chk.sv -----
// Port-level checker for the sorted timer queue, bound to the top level.
`default_nettype none

module stq_chk import stq_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input cmd_t    cmd,
	input logic    result_valid,
	input result_t result
);

	// a final result is never directly followed by another
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last_result |=> !result_valid)
		else $error("result straight after a final result");

	// more results to come means the unit is still working
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |-> busy)
		else $error("non-final result while idle");

	// only fired results can come in a series
	a_query_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind != KIND_FIRED) |-> result.last_result)
		else $error("query answer not marked final");

	a_fired_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.result_kind == KIND_FIRED) |-> !result.answer_flag)
		else $error("fired result with answer flag set");

	// arm and cancel give no result
	a_silent_update: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((cmd.opcode == OP_ARM) || (cmd.opcode == OP_CANCEL))
		|=> !result_valid)
		else $error("result after arm or cancel");

endmodule

bind sorted_timer_queue_unit stq_chk u_stq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.cmd          (cmd),
	.result_valid (result_valid),
	.result       (result)
);

`default_nettype wire

// ----- tb/sorted_timer_queue_unit_test.sv -----
// Self-checking testbench for the sorted timer queue: directed table, then random commands.
`default_nettype none

module sorted_timer_queue_unit_test;
	import stq_pkg::*;

	// Reserved opcodes, which the block must ignore
	localparam logic [2:0] OP_RSVD5 = 3'd5;
	localparam logic [2:0] OP_RSVD6 = 3'd6;
	localparam logic [2:0] OP_RSVD7 = 3'd7;

	localparam logic signed [TIME_W-1:0] T_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [TIME_W-1:0] T_MAX = 64'sh7fff_ffff_ffff_ffff;

	// Covers the worst arm scan plus the result register
	localparam int SETTLE_CYCLES = 2 * NUM_TIMERS + 8;
	localparam int RANDOM_ITEMS  = 255;
	// Well above the slowest honest run of the whole test
	localparam int CYCLE_LIMIT   = 250000;
	localparam int REPORT_MAX    = 10;

	typedef struct {
		cmd_t    c;
		bit      typed;    // want holds the single result, typed in by hand
		result_t want;
	} plan_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	cmd_t    cmd;
	logic    result_valid;
	result_t result;

	// Side channel that travels with each command into the checker
	bit      row_typed;
	result_t row_want;

	// Predictor state: the timer list, head first
	logic [TID_W-1:0]         list_id     [NUM_TIMERS];
	logic signed [TIME_W-1:0] list_expire [NUM_TIMERS];
	int                       list_len;

	result_t awaited_results[$];
	int      mismatches;
	int      cycles;

	logic signed [TIME_W-1:0] tick_base;
	bit                       quiet;

	plan_row_t plan[$];

	sorted_timer_queue_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result       (result)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor of the timer list
	// ---------------------------------------------------------------

	// Position of a timer in the list, or -1 when not armed
	function automatic int find_timer(input logic [TID_W-1:0] id);
		for (int i = 0; i < list_len; i++)
			if (list_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic void drop_at(input int pos);
		if (pos < 0 || pos >= list_len)
			return;
		for (int i = pos; i + 1 < list_len; i++) begin
			list_id[i]     = list_id[i + 1];
			list_expire[i] = list_expire[i + 1];
		end
		list_len--;
	endfunction

	// Goes behind every entry that is not later, so equal times keep arming order
	function automatic void insert_sorted(input logic [TID_W-1:0] id,
			input logic signed [TIME_W-1:0] when);
		int pos;
		pos = 0;
		if (list_len >= NUM_TIMERS)
			return;
		while (pos < list_len && !(list_expire[pos] > when))
			pos++;
		for (int i = list_len; i > pos; i--) begin
			list_id[i]     = list_id[i - 1];
			list_expire[i] = list_expire[i - 1];
		end
		list_id[pos]     = id;
		list_expire[pos] = when;
		list_len++;
	endfunction

	// Applies one accepted command and queues the results it must produce
	function automatic void apply_command(input cmd_t c, input bit typed,
			input result_t want);
		result_t made[$];
		result_t r;
		int      fired;
		fired = 0;
		case (c.opcode)
			OP_ARM: begin
				if (c.timer_id < NUM_TIMERS) begin
					drop_at(find_timer(c.timer_id));
					insert_sorted(c.timer_id, $signed(c.expire_at));
				end
			end
			OP_CANCEL: begin
				if (c.timer_id < NUM_TIMERS)
					drop_at(find_timer(c.timer_id));
			end
			OP_PENDING: begin
				r = '{KIND_PENDING, c.timer_id, find_timer(c.timer_id) >= 0, 1'b1};
				made.push_back(r);
			end
			OP_EXPIRED: begin
				if (list_len > 0)
					r = '{KIND_EXPIRED, list_id[0],
						!(list_expire[0] > $signed(c.now_time)), 1'b1};
				else
					r = '{KIND_EXPIRED, '0, 1'b0, 1'b1};
				made.push_back(r);
			end
			OP_RUN: begin
				while (fired < NUM_TIMERS && list_len > 0 &&
						!(list_expire[0] > $signed(c.now_time))) begin
					r = '{KIND_FIRED, list_id[0], 1'b0, 1'b0};
					made.push_back(r);
					drop_at(0);
					fired++;
				end
				if (made.size() > 0)
					made[made.size() - 1].last_result = 1'b1;
			end
			default: ; // reserved opcodes leave the list alone
		endcase
		if (typed)
			awaited_results.push_back(want);
		else
			foreach (made[i])
				awaited_results.push_back(made[i]);
	endfunction

	// ---------------------------------------------------------------
	// Checker: results first, then the command accepted at this edge
	// ---------------------------------------------------------------

	function automatic void report_mismatch(input string what, input result_t want,
			input result_t got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch (%s) at cycle %0d: ", what, cycles,
				"expected kind %0d id %0d flag %0d last %0d, ",
				want.result_kind, want.fired_id, want.answer_flag, want.last_result,
				"got kind %0d id %0d flag %0d last %0d",
				got.result_kind, got.fired_id, got.answer_flag, got.last_result);
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (result_valid) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected", '0, result);
				end else begin
					want = awaited_results.pop_front();
					if (result.result_kind !== want.result_kind)
						report_mismatch("result_kind", want, result);
					else if (result.fired_id !== want.fired_id)
						report_mismatch("fired_id", want, result);
					else if (result.answer_flag !== want.answer_flag)
						report_mismatch("answer_flag", want, result);
					else if (result.last_result !== want.last_result)
						report_mismatch("last_result", want, result);
				end
			end
			if (start && !busy)
				apply_command(cmd, row_typed, row_want);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------

	// One command transfer: optional idle gap, then hold start until busy is low.
	// start stays high on return so back-to-back commands need no second write.
	task automatic send_cmd(input cmd_t c, input bit typed, input result_t want);
		int gap;
		if ($urandom_range(0, 24) == 0)
			quiet = !quiet;
		gap = quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		cmd       <= c;
		row_typed <= typed;
		row_want  <= want;
		do
			@(posedge clk);
		while (busy);
	endtask

	function automatic plan_row_t plan_row(input logic [2:0] op, input int id,
			input logic signed [TIME_W-1:0] when, input logic signed [TIME_W-1:0] now,
			input bit typed, input result_t want);
		plan_row_t row;
		row.c     = '{op, TID_W'(id), when, now};
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	// Mostly near the running time base so runs find work; some extremes and
	// full-width values so every bit toggles
	function automatic logic signed [TIME_W-1:0] pick_time();
		int sel;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			return T_MIN;
		if (sel == 1)
			return T_MAX;
		if (sel <= 3)
			return {$urandom, $urandom};
		return tick_base + longint'($urandom_range(0, 40)) - 64'sd10;
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t c;
		int   sel;
		c.timer_id  = TID_W'($urandom_range(0, 15));
		c.expire_at = {$urandom, $urandom};
		c.now_time  = {$urandom, $urandom};
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			c.opcode    = OP_ARM;
			c.expire_at = pick_time();
		end else if (sel < 50) begin
			c.opcode = OP_CANCEL;
		end else if (sel < 65) begin
			c.opcode = OP_PENDING;
		end else if (sel < 75) begin
			c.opcode   = OP_EXPIRED;
			c.now_time = pick_time();
		end else if (sel < 95) begin
			c.opcode   = OP_RUN;
			tick_base  = tick_base + longint'($urandom_range(0, 12));
			c.now_time = ($urandom_range(0, 3) != 0) ? tick_base : pick_time();
		end else begin
			c.opcode = 3'($urandom_range(OP_RSVD5, OP_RSVD7));
		end
		return c;
	endfunction

	initial begin
		cmd_t c;
		int   counted;
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		row_typed       = 1'b0;
		row_want        = '0;
		list_len        = 0;
		mismatches      = 0;
		cycles          = 0;
		tick_base       = '0;
		quiet           = 1'b0;
		counted         = 0;

		// Directed table. Typed rows carry the one result they must produce.
		// Empty list straight after reset
		plan.push_back(plan_row(OP_PENDING, 0, 0, 0, 1, '{KIND_PENDING, 0, 1'b0, 1'b1}));
		plan.push_back(plan_row(OP_EXPIRED, 0, 0, T_MAX, 1, '{KIND_EXPIRED, 0, 1'b0, 1'b1}));
		plan.push_back(plan_row(OP_RUN, 0, 0, T_MAX, 0, '0));
		// Extreme expire times, then a tie and a re-arm that moves behind it
		plan.push_back(plan_row(OP_ARM, 15, T_MAX, 0, 0, '0));
		plan.push_back(plan_row(OP_ARM, 0, T_MIN, 0, 0, '0));
		plan.push_back(plan_row(OP_ARM, 7, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_ARM, 8, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_ARM, 7, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_PENDING, 15, 0, 0, 1, '{KIND_PENDING, 15, 1'b1, 1'b1}));
		plan.push_back(plan_row(OP_EXPIRED, 0, 0, T_MIN, 1, '{KIND_EXPIRED, 0, 1'b1, 1'b1}));
		// Cancel of a timer that is not armed, then a real one
		plan.push_back(plan_row(OP_CANCEL, 3, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_CANCEL, 0, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_EXPIRED, 0, 0, -64'sd1, 1, '{KIND_EXPIRED, 8, 1'b0, 1'b1}));
		// Reserved opcodes with every field bit set
		plan.push_back(plan_row(OP_RSVD5, 15, -64'sd1, -64'sd1, 0, '0));
		plan.push_back(plan_row(OP_RSVD6, 15, -64'sd1, -64'sd1, 0, '0));
		plan.push_back(plan_row(OP_RSVD7, 15, -64'sd1, -64'sd1, 0, '0));
		// Tied pair fires in arming order, the far one last
		plan.push_back(plan_row(OP_RUN, 0, 0, 0, 0, '0));
		plan.push_back(plan_row(OP_PENDING, 7, 0, 0, 1, '{KIND_PENDING, 7, 1'b0, 1'b1}));
		plan.push_back(plan_row(OP_RUN, 0, 0, T_MAX, 1, '{KIND_FIRED, 15, 1'b0, 1'b1}));
		plan.push_back(plan_row(OP_PENDING, 15, 0, 0, 1, '{KIND_PENDING, 15, 1'b0, 1'b1}));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_cmd(plan[i].c, plan[i].typed, plan[i].want);

		// Random part; now and then fill all timers and drain them in one run
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(0, 39) == 0) begin
				for (int id = 0; id < NUM_TIMERS; id++) begin
					c = '{OP_ARM, TID_W'(id), pick_time(), {$urandom, $urandom}};
					send_cmd(c, 1'b0, '0);
				end
				c = '{OP_RUN, TID_W'($urandom_range(0, 15)), {$urandom, $urandom}, T_MAX};
				send_cmd(c, 1'b0, '0);
				counted += NUM_TIMERS + 1;
			end else begin
				c = random_cmd();
				send_cmd(c, 1'b0, '0);
				if (c.opcode <= OP_RUN)
					counted++;
			end
		end
		start <= 1'b0;

		// Drain, then give a trailing arm or cancel time to finish
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && awaited_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/stq_pkg.sv
rtl/core/stq_cmp.sv
rtl/core/sorted_timer_queue_unit.sv
rtl/core/stq_chk.sv
tb/sorted_timer_queue_unit_test.sv
